FILE: src/assert_macros.svh
// Assertion macros for the checker module of the replay record parser.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion sampled on the rising clock edge, switched off while reset is held.
`define IRP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Concurrent assertion that is also checked while reset is held.
`define IRP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

FILE: src/irp_pkg.sv
// Types, constants and register indexes shared by the replay record parser files.
package irp_pkg;

  localparam int CfgDataWidth   = 32;
  localparam int CfgIdxWidthDef = 8;
  localparam int TdataWidth     = 216;

  // Register indexes on the configuration port.
  localparam int RegFrameLimit   = 0;
  localparam int RegSeedsEnabled = 1;

  // Field lengths in bytes, taken modulo eight as the byte counter wraps.
  localparam logic [2:0] OptionsBytes = 3'd2;
  localparam logic [2:0] SeedBytes    = 3'd0;
  localparam logic [2:0] ButtonsBytes = 3'd2;

  typedef enum logic [6:0] {
    PhDelta   = 7'b0000001,
    PhOptions = 7'b0000010,
    PhSeed1   = 7'b0000100,
    PhSeed2   = 7'b0001000,
    PhButtons = 7'b0010000,
    PhStickX  = 7'b0100000,
    PhStickY  = 7'b1000000
  } irp_phase_e;

  typedef struct packed {
    logic [31:0] frame_limit;
    logic        seeds_enabled;
  } irp_cfg_t;

  typedef struct packed {
    logic               record_kind;
    logic [15:0]        options_word;
    logic [7:0]         frame_delta;
    logic [63:0]        first_seed;
    logic [63:0]        second_seed;
    logic [15:0]        button_bits;
    logic signed [7:0]  stick_horizontal;
    logic signed [7:0]  stick_vertical;
    logic [31:0]        frame_number;
    logic               last_frame;
  } irp_rec_t;

  localparam logic KindOptions = 1'b0;
  localparam logic KindFrame   = 1'b1;

endpackage

FILE: src/input_replay_record_parser.sv
// Top level of the controller-replay record parser with configuration and output buffering.
//
// The block takes the record stream that follows a replay header, one byte per
// transaction on the s_axis channel, and emits one decoded record per
// transaction on the m_axis channel. A zero delta byte opens an options record
// (a big-endian 16-bit word follows); any other delta opens a frame record
// carrying, when seeds are enabled, two big-endian 64-bit seeds, then a
// 16-bit button mask and the signed stick X and Y bytes.
// Throughput is one byte per cycle while s_axis_tready_o is high. A record is
// registered from the byte that ends it; all other bytes yield nothing.
// Parsing stops once frame_limit frame records have been produced: the last
// one has tlast set and every later byte is accepted and discarded.
// The configuration channel is always ready; register 0 is frame_limit and
// register 1 is seeds_enabled. Writes are meant to happen while the parser is
// idle; seeds_enabled is sampled at each delta byte.
// Reset clears both registers, so nothing is parsed until frame_limit is set.
// When the receiver stalls, a second record is held in a skid register and
// s_axis_tready_o only drops while that register is occupied.
module input_replay_record_parser #(
  parameter int CfgIdxWidth = irp_pkg::CfgIdxWidthDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Record stream bytes. tdata: stream_byte [7:0].
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  input  logic [7:0]                        s_axis_tdata_i,
  // Decoded records. tdata, lowest bit first: options_word [15:0],
  // frame_delta [23:16], first_seed [87:24], second_seed [151:88],
  // button_bits [167:152], stick_horizontal [175:168],
  // stick_vertical [183:176], frame_number [215:184].
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  output logic [irp_pkg::TdataWidth-1:0]    m_axis_tdata_o,
  // tuser: record_kind [0] (0 options record, 1 frame record).
  output logic                              m_axis_tuser_o,
  // tlast: last_frame.
  output logic                              m_axis_tlast_o,
  // Register writes.
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [CfgIdxWidth-1:0]            cfg_index_i,
  input  logic [irp_pkg::CfgDataWidth-1:0]  cfg_data_i
);
  import irp_pkg::*;

  irp_cfg_t cfg_q, cfg_d;

  logic     in_take;
  logic     out_take;
  logic     res_valid;
  irp_rec_t res_rec;

  logic     out_valid_q, out_valid_d;
  irp_rec_t out_rec_q, out_rec_d;
  logic     skid_valid_q, skid_valid_d;
  irp_rec_t skid_rec_q, skid_rec_d;

  // Configuration registers; writes to unknown indexes are dropped.
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      if (cfg_index_i == CfgIdxWidth'(RegFrameLimit)) begin
        cfg_d.frame_limit = cfg_data_i;
      end else if (cfg_index_i == CfgIdxWidth'(RegSeedsEnabled)) begin
        cfg_d.seeds_enabled = cfg_data_i[0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // The input stalls only while the skid register holds a record.
  assign s_axis_tready_o = !skid_valid_q;
  assign in_take         = s_axis_tvalid_i && s_axis_tready_o;
  assign out_take        = out_valid_q && m_axis_tready_i;

  irp_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_valid_i (in_take),
    .byte_i       (s_axis_tdata_i),
    .cfg_i        (cfg_q),
    .rec_valid_o  (res_valid),
    .rec_o        (res_rec)
  );

  // Output register with a skid register behind it. A fresh record goes
  // straight to the output when that is free, otherwise into the skid
  // register, which drains into the output as soon as the receiver takes.
  always_comb begin
    out_valid_d  = out_valid_q;
    out_rec_d    = out_rec_q;
    skid_valid_d = skid_valid_q;
    skid_rec_d   = skid_rec_q;
    if (!out_valid_q || out_take) begin
      if (skid_valid_q) begin
        out_valid_d  = 1'b1;
        out_rec_d    = skid_rec_q;
        skid_valid_d = 1'b0;
      end else if (res_valid) begin
        out_valid_d = 1'b1;
        out_rec_d   = res_rec;
      end else begin
        out_valid_d = 1'b0;
      end
    end else if (res_valid) begin
      skid_valid_d = 1'b1;
      skid_rec_d   = res_rec;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_rec_q  <= out_rec_d;
    skid_rec_q <= skid_rec_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_rec_q.record_kind;
  assign m_axis_tlast_o  = out_rec_q.last_frame;
  assign m_axis_tdata_o  = {out_rec_q.frame_number,
                            out_rec_q.stick_vertical,
                            out_rec_q.stick_horizontal,
                            out_rec_q.button_bits,
                            out_rec_q.second_seed,
                            out_rec_q.first_seed,
                            out_rec_q.frame_delta,
                            out_rec_q.options_word};

endmodule

FILE: src/irp_parser.sv
// Byte-wise record parser: phase tracking, field assembly and record building.
module irp_parser (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        byte_valid_i,
  input  logic [7:0]                  byte_i,
  input  irp_pkg::irp_cfg_t           cfg_i,
  output logic                        rec_valid_o,
  output irp_pkg::irp_rec_t           rec_o
);
  import irp_pkg::*;

  irp_phase_e  phase_q, phase_d;
  logic [2:0]  cnt_q, cnt_d;
  logic [63:0] shift_q, shift_d;
  logic [7:0]  delta_q, delta_d;
  logic [63:0] seed1_q, seed1_d;
  logic [63:0] seed2_q, seed2_d;
  logic [15:0] buttons_q, buttons_d;
  logic [7:0]  stick_x_q, stick_x_d;
  logic [31:0] frames_q, frames_d;

  logic [63:0] gathered;
  logic [2:0]  cnt_inc;

  assign gathered = {shift_q[55:0], byte_i};
  assign cnt_inc  = cnt_q + 3'd1;

  always_comb begin
    phase_d     = phase_q;
    cnt_d       = cnt_q;
    shift_d     = shift_q;
    delta_d     = delta_q;
    seed1_d     = seed1_q;
    seed2_d     = seed2_q;
    buttons_d   = buttons_q;
    stick_x_d   = stick_x_q;
    frames_d    = frames_q;
    rec_valid_o = 1'b0;
    rec_o       = '0;
    if (byte_valid_i) begin
      unique case (phase_q)
        PhDelta: begin
          // Once the frame budget is spent every further byte is dropped.
          if (frames_q < cfg_i.frame_limit) begin
            cnt_d   = 3'd0;
            shift_d = '0;
            if (byte_i == 8'd0) begin
              phase_d = PhOptions;
            end else begin
              delta_d = byte_i;
              seed1_d = '0;
              seed2_d = '0;
              phase_d = cfg_i.seeds_enabled ? PhSeed1 : PhButtons;
            end
          end
        end
        PhOptions: begin
          shift_d = gathered;
          cnt_d   = cnt_inc;
          if (cnt_inc == OptionsBytes) begin
            cnt_d              = 3'd0;
            rec_valid_o        = 1'b1;
            rec_o.record_kind  = KindOptions;
            rec_o.options_word = gathered[15:0];
            phase_d            = PhDelta;
          end
        end
        PhSeed1: begin
          shift_d = gathered;
          cnt_d   = cnt_inc;
          if (cnt_inc == SeedBytes) begin
            cnt_d   = 3'd0;
            seed1_d = gathered;
            phase_d = PhSeed2;
          end
        end
        PhSeed2: begin
          shift_d = gathered;
          cnt_d   = cnt_inc;
          if (cnt_inc == SeedBytes) begin
            cnt_d   = 3'd0;
            seed2_d = gathered;
            phase_d = PhButtons;
          end
        end
        PhButtons: begin
          shift_d = gathered;
          cnt_d   = cnt_inc;
          if (cnt_inc == ButtonsBytes) begin
            cnt_d     = 3'd0;
            buttons_d = gathered[15:0];
            phase_d   = PhStickX;
          end
        end
        PhStickX: begin
          stick_x_d = byte_i;
          phase_d   = PhStickY;
        end
        PhStickY: begin
          frames_d               = frames_q + 32'd1;
          rec_valid_o            = 1'b1;
          rec_o.record_kind      = KindFrame;
          rec_o.frame_delta      = delta_q;
          rec_o.first_seed       = seed1_q;
          rec_o.second_seed      = seed2_q;
          rec_o.button_bits      = buttons_q;
          rec_o.stick_horizontal = $signed(stick_x_q);
          rec_o.stick_vertical   = $signed(byte_i);
          rec_o.frame_number     = frames_q;
          rec_o.last_frame       = (frames_d >= cfg_i.frame_limit);
          cnt_d                  = 3'd0;
          phase_d                = PhDelta;
        end
        default: begin
          phase_d = PhDelta;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhDelta;
      cnt_q     <= '0;
      shift_q   <= '0;
      delta_q   <= '0;
      seed1_q   <= '0;
      seed2_q   <= '0;
      buttons_q <= '0;
      stick_x_q <= '0;
      frames_q  <= '0;
    end else begin
      phase_q   <= phase_d;
      cnt_q     <= cnt_d;
      shift_q   <= shift_d;
      delta_q   <= delta_d;
      seed1_q   <= seed1_d;
      seed2_q   <= seed2_d;
      buttons_q <= buttons_d;
      stick_x_q <= stick_x_d;
      frames_q  <= frames_d;
    end
  end

endmodule

FILE: src/irp_checker.sv
// Port-level assertion checker for the replay record parser and its bind statement.
`include "assert_macros.svh"

module irp_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid_i,
  input logic                           s_axis_tready_o,
  input logic                           m_axis_tvalid_o,
  input logic                           m_axis_tready_i,
  input logic [irp_pkg::TdataWidth-1:0] m_axis_tdata_o,
  input logic                           m_axis_tuser_o,
  input logic                           m_axis_tlast_o
);
  import irp_pkg::*;

  logic out_stall;
  logic in_take;
  logic out_is_options;
  logic frame_fields_clear;

  assign out_stall          = m_axis_tvalid_o && !m_axis_tready_i;
  assign in_take            = s_axis_tvalid_i && s_axis_tready_o;
  assign out_is_options     = m_axis_tvalid_o && (m_axis_tuser_o == KindOptions);
  assign frame_fields_clear = (m_axis_tdata_o[TdataWidth-1:16] == '0) && !m_axis_tlast_o;

  // A stalled record must not change or vanish.
  `IRP_ASSERT(a_out_hold, out_stall |=> m_axis_tvalid_o && $stable(m_axis_tdata_o), "stall broken")

  // Reset empties the output stage from the first clock edge it sees onwards.
  `IRP_ASSERT_ALWAYS(a_reset_empty, !rst_ni |=> !m_axis_tvalid_o, "record shown during reset")

  // The input may only stall when a record is waiting at the output.
  `IRP_ASSERT(a_stall_cause, !s_axis_tready_o |-> m_axis_tvalid_o, "input stalled, output empty")

  // A record that newly appears at the output comes from a byte accepted in the cycle before.
  `IRP_ASSERT(a_no_invented, $rose(m_axis_tvalid_o) |-> $past(in_take), "record without input byte")

  // Options records carry nothing but the options word.
  `IRP_ASSERT(a_options_clean, out_is_options |-> frame_fields_clear, "options record not clean")

endmodule

bind input_replay_record_parser irp_checker u_irp_checker (.*);

FILE: bench/tb_top.sv
// Self-checking testbench for the replay record parser: directed table, then random byte streams.
module tb_top;
  import irp_pkg::*;

  // Clock, reset and the signals driven into the parser.
  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    s_axis_tvalid = 1'b0;
  logic [7:0]              s_axis_tdata = '0;
  logic                    m_axis_tready = 1'b0;
  logic                    cfg_valid = 1'b0;
  logic [7:0]              cfg_index = '0;
  logic [CfgDataWidth-1:0] cfg_data = '0;

  logic                    s_axis_tready_o;
  logic                    m_axis_tvalid_o;
  logic [TdataWidth-1:0]   m_axis_tdata_o;
  logic                    m_axis_tuser_o;
  logic                    m_axis_tlast_o;
  logic                    cfg_ready_o;

  input_replay_record_parser dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o),
    .m_axis_tlast_o (m_axis_tlast_o),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Generous ceiling on the whole run; only a hung handshake should ever reach it.
  initial begin
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Parser mirror: our own copy of the registers and of the parsing state.
  // ---------------------------------------------------------------------------
  logic [31:0] lim_copy = '0;
  logic        seeds_copy = 1'b0;
  irp_phase_e  parse_ph = PhDelta;
  logic [2:0]  nb_cnt = '0;
  logic [63:0] asm_shift = '0;
  logic [7:0]  hold_delta = '0;
  logic [63:0] hold_seed_a = '0;
  logic [63:0] hold_seed_b = '0;
  logic [15:0] hold_buttons = '0;
  logic [7:0]  hold_x = '0;
  logic [31:0] frames_parsed = '0;

  // Records that the parser owes us, oldest first.
  irp_rec_t records_due[$];

  int fault_count = 0;
  int live_bytes = 0;
  int skipped_bytes = 0;
  int options_seen = 0;
  int frames_seen = 0;
  int last_seen = 0;
  int phase_count = 0;
  bit quiet_phase = 1'b0;
  bit backlog_req = 1'b0;

  // Shifts one byte into the field being assembled; true once len bytes are in.
  // The byte counter wraps at eight, so a seed field has length zero.
  function automatic bit take_field(input logic [7:0] b, input logic [2:0] len);
    asm_shift = {asm_shift[55:0], b};
    nb_cnt = nb_cnt + 3'd1;
    if (nb_cnt == len) begin
      nb_cnt = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Advances the mirror by one accepted byte. took is low when the stopped
  // parser drops the byte; made is high when a record is completed.
  task automatic parse_byte(input logic [7:0] b, output bit took, output bit made,
                            output irp_rec_t rec);
    took = 1'b1;
    made = 1'b0;
    rec = '0;
    case (parse_ph)
      PhDelta: begin
        // The frame limit gates a new record here, at its start; it also sets the last-frame flag.
        if (frames_parsed >= lim_copy) begin
          took = 1'b0;
        end else begin
          nb_cnt = '0;
          asm_shift = '0;
          if (b == 8'h00) begin
            parse_ph = PhOptions;
          end else begin
            hold_delta = b;
            hold_seed_a = '0;
            hold_seed_b = '0;
            parse_ph = seeds_copy ? PhSeed1 : PhButtons;
          end
        end
      end
      PhOptions: begin
        if (take_field(b, OptionsBytes)) begin
          rec.record_kind = KindOptions;
          rec.options_word = asm_shift[15:0];
          made = 1'b1;
          parse_ph = PhDelta;
        end
      end
      PhSeed1: begin
        if (take_field(b, SeedBytes)) begin
          hold_seed_a = asm_shift;
          parse_ph = PhSeed2;
        end
      end
      PhSeed2: begin
        if (take_field(b, SeedBytes)) begin
          hold_seed_b = asm_shift;
          parse_ph = PhButtons;
        end
      end
      PhButtons: begin
        if (take_field(b, ButtonsBytes)) begin
          hold_buttons = asm_shift[15:0];
          parse_ph = PhStickX;
        end
      end
      PhStickX: begin
        hold_x = b;
        parse_ph = PhStickY;
      end
      default: begin
        rec.record_kind = KindFrame;
        rec.frame_delta = hold_delta;
        rec.first_seed = hold_seed_a;
        rec.second_seed = hold_seed_b;
        rec.button_bits = hold_buttons;
        rec.stick_horizontal = hold_x;
        rec.stick_vertical = b;
        rec.frame_number = frames_parsed;
        frames_parsed = frames_parsed + 32'd1;
        rec.last_frame = (frames_parsed >= lim_copy);
        made = 1'b1;
        parse_ph = PhDelta;
        nb_cnt = '0;
      end
    endcase
  endtask

  // Idle length: zero with the given percentage, otherwise mostly short, now
  // and then long.
  function automatic int pause_len(input int none_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < none_pct) return 0;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(15, 40);
  endfunction

  // Offers one byte, waits for the transaction and books what it causes.
  // A typed expectation from the directed table takes the place of the mirror's.
  task automatic push_byte(input logic [7:0] b, input bit typed, input irp_rec_t typed_rec);
    int gap;
    bit took;
    bit made;
    irp_rec_t rec;
    gap = quiet_phase ? 0 : pause_len(55);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= b;
    do @(posedge clk_i); while (!s_axis_tready_o);
    parse_byte(b, took, made, rec);
    if (typed) records_due.push_back(typed_rec);
    else if (made) records_due.push_back(rec);
    if (took) live_bytes++;
    else skipped_bytes++;
  endtask

  // Register write, only once the parser owes nothing and has had time to
  // finish any byte still in its pipeline.
  task automatic write_reg(input int idx, input logic [31:0] val);
    s_axis_tvalid <= 1'b0;
    while (records_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx[7:0];
    cfg_data <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid <= 1'b0;
    if (idx == RegFrameLimit) lim_copy = val;
    else if (idx == RegSeedsEnabled) seeds_copy = val[0];
  endtask

  // Next random byte: well-formed in that a record opener is mostly a frame
  // delta and sometimes an options marker, with the field bytes biased to
  // their extremes.
  function automatic logic [7:0] next_byte();
    if (parse_ph == PhDelta) begin
      if ($urandom_range(0, 4) == 0) return 8'h00;
      return 8'($urandom_range(1, 255));
    end
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h80;
      3: return 8'h7F;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Directed table.
  // ---------------------------------------------------------------------------
  typedef struct {
    bit          is_reg;
    int          reg_idx;
    logic [31:0] reg_val;
    logic [7:0]  b;
    bit          typed;
    irp_rec_t    rec;
  } plan_row_t;

  plan_row_t plan[$];

  function automatic plan_row_t reg_row(input int idx, input logic [31:0] val);
    plan_row_t row;
    row = '{default: '0};
    row.is_reg = 1'b1;
    row.reg_idx = idx;
    row.reg_val = val;
    return row;
  endfunction

  function automatic plan_row_t byte_row(input logic [7:0] b);
    plan_row_t row;
    row = '{default: '0};
    row.b = b;
    return row;
  endfunction

  function automatic plan_row_t rec_row(input logic [7:0] b, input irp_rec_t rec);
    plan_row_t row;
    row = byte_row(b);
    row.typed = 1'b1;
    row.rec = rec;
    return row;
  endfunction

  function automatic irp_rec_t options_expect(input logic [15:0] w);
    irp_rec_t rec;
    rec = '0;
    rec.record_kind = KindOptions;
    rec.options_word = w;
    return rec;
  endfunction

  function automatic irp_rec_t frame_expect(input logic [7:0] delta, input logic [15:0] btn,
                                            input logic [7:0] x, input logic [7:0] y,
                                            input logic [31:0] num, input logic last);
    irp_rec_t rec;
    rec = '0;
    rec.record_kind = KindFrame;
    rec.frame_delta = delta;
    rec.button_bits = btn;
    rec.stick_horizontal = x;
    rec.stick_vertical = y;
    rec.frame_number = num;
    rec.last_frame = last;
    return rec;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus.
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int n;
    logic [31:0] lim;
    logic        seeds;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Out of reset the frame limit is zero: even an options record is dropped.
    plan.push_back(byte_row(8'h00));
    plan.push_back(byte_row(8'h5A));
    plan.push_back(reg_row(RegFrameLimit, 32'd2));
    plan.push_back(reg_row(RegSeedsEnabled, 32'd0));
    plan.push_back(byte_row(8'h00));
    plan.push_back(byte_row(8'hFF));
    plan.push_back(rec_row(8'hFF, options_expect(16'hFFFF)));
    // Largest delta, empty button mask, stick at its most negative X and most positive Y.
    plan.push_back(byte_row(8'hFF));
    plan.push_back(byte_row(8'h00));
    plan.push_back(byte_row(8'h00));
    plan.push_back(byte_row(8'h80));
    plan.push_back(rec_row(8'h7F, frame_expect(8'hFF, 16'h0000, 8'h80, 8'h7F, 32'd0, 1'b0)));
    // A record already opened runs to its end although seed mode is switched
    // on and the limit dropped to zero under it; it becomes the last frame.
    plan.push_back(byte_row(8'h01));
    plan.push_back(reg_row(RegSeedsEnabled, 32'd1));
    plan.push_back(reg_row(RegFrameLimit, 32'd0));
    plan.push_back(byte_row(8'hFF));
    plan.push_back(byte_row(8'hFF));
    plan.push_back(byte_row(8'h7F));
    plan.push_back(rec_row(8'h80, frame_expect(8'h01, 16'hFFFF, 8'h7F, 8'h80, 32'd1, 1'b1)));
    // Stopped again, so this byte goes nowhere.
    plan.push_back(byte_row(8'hA5));
    plan.push_back(reg_row(RegFrameLimit, 32'hFFFF_FFFF));
    plan.push_back(byte_row(8'h00));
    plan.push_back(byte_row(8'h00));
    plan.push_back(rec_row(8'h00, options_expect(16'h0000)));

    foreach (plan[i]) begin
      if (plan[i].is_reg) write_reg(plan[i].reg_idx, plan[i].reg_val);
      else push_byte(plan[i].b, plan[i].typed, plan[i].rec);
    end

    // Random phases. Each one picks new register values and then sends a
    // random number of bytes, so phases often end inside a record. Dropped
    // bytes count towards the total as well.
    while (live_bytes + skipped_bytes < 550) begin
      phase_count++;
      seeds = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 5))
        0: lim = 32'hFFFF_FFFF;
        1: lim = frames_parsed;
        2, 3: lim = frames_parsed + 32'($urandom_range(1, 4));
        default: lim = frames_parsed + 32'($urandom_range(5, 20));
      endcase
      quiet_phase = 1'b0;
      n = $urandom_range(20, 90);
      if (phase_count == 3) begin
        // Back-pressure phase: short frames sent flat out while the receiver
        // holds off long enough for the parser to fill and stall its input.
        seeds = 1'b0;
        lim = 32'hFFFF_FFFF;
        n = 120;
      end
      if ($urandom_range(0, 1) == 0) begin
        write_reg(RegSeedsEnabled, {31'd0, seeds});
        write_reg(RegFrameLimit, lim);
      end else begin
        write_reg(RegFrameLimit, lim);
        write_reg(RegSeedsEnabled, {31'd0, seeds});
      end
      quiet_phase = (phase_count == 3) || ($urandom_range(0, 4) == 0);
      if (phase_count == 3) backlog_req = 1'b1;
      repeat (n) push_byte(next_byte(), 1'b0, '0);
    end

    s_axis_tvalid <= 1'b0;
    quiet_phase = 1'b0;
    while (records_due.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("Covered %0d stream bytes parsed and %0d dropped while stopped, over %0d phases.",
             live_bytes, skipped_bytes, phase_count);
    $display("Records checked: %0d options, %0d frames, %0d of them flagged last.",
             options_seen, frames_seen, last_seen);
    if (fault_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Receiver: random back-pressure and the record check.
  // ---------------------------------------------------------------------------
  task automatic compare_field(input string name, input logic [63:0] want,
                               input logic [63:0] seen);
    if (want !== seen) begin
      $error("%s: expected %0h, got %0h", name, want, seen);
      fault_count++;
    end
  endtask

  initial begin : receiver
    int hold;
    irp_rec_t want;
    irp_rec_t got;
    hold = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid_o && m_axis_tready) begin
        got.record_kind = m_axis_tuser_o;
        got.options_word = m_axis_tdata_o[15:0];
        got.frame_delta = m_axis_tdata_o[23:16];
        got.first_seed = m_axis_tdata_o[87:24];
        got.second_seed = m_axis_tdata_o[151:88];
        got.button_bits = m_axis_tdata_o[167:152];
        got.stick_horizontal = m_axis_tdata_o[175:168];
        got.stick_vertical = m_axis_tdata_o[183:176];
        got.frame_number = m_axis_tdata_o[215:184];
        got.last_frame = m_axis_tlast_o;
        if (records_due.size() == 0) begin
          $error("record transaction with none expected: kind %0b, tdata %0h",
                 got.record_kind, m_axis_tdata_o);
          fault_count++;
        end else begin
          want = records_due.pop_front();
          compare_field("record_kind", 64'(want.record_kind), 64'(got.record_kind));
          compare_field("options_word", 64'(want.options_word), 64'(got.options_word));
          compare_field("frame_delta", 64'(want.frame_delta), 64'(got.frame_delta));
          compare_field("first_seed", want.first_seed, got.first_seed);
          compare_field("second_seed", want.second_seed, got.second_seed);
          compare_field("button_bits", 64'(want.button_bits), 64'(got.button_bits));
          compare_field("stick_horizontal", 64'($unsigned(want.stick_horizontal)),
                        64'($unsigned(got.stick_horizontal)));
          compare_field("stick_vertical", 64'($unsigned(want.stick_vertical)),
                        64'($unsigned(got.stick_vertical)));
          compare_field("frame_number", 64'(want.frame_number), 64'(got.frame_number));
          compare_field("last_frame", 64'(want.last_frame), 64'(got.last_frame));
          if (want.record_kind == KindOptions) options_seen++;
          else frames_seen++;
          if (want.last_frame) last_seen++;
        end
      end
      // The long hold-off is counted here, independent of the sender.
      if (backlog_req) begin
        hold = 200;
        backlog_req = 1'b0;
      end else if (hold == 0 && !quiet_phase) begin
        hold = pause_len(65);
      end
      if (hold > 0) begin
        m_axis_tready <= 1'b0;
        hold--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

endmodule
